[rtl/ccc_pkg.sv]
// ccc_pkg: field widths, limits and transaction types of the calendar clock counter
// no dependencies; imported by calendar_clock_counter and ccc_checker
package ccc_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int YDAY_W  = 9;

  // time and date limits
  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [WDAY_W-1:0]  WDAY_MAX  = 3'd6;

  // reset date: Saturday 1 January 2000, 00:00:00
  localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;
  localparam logic [WDAY_W-1:0]  WDAY_RST  = 3'd6;
  localparam logic [YDAY_W-1:0]  YDAY_RST  = 9'd1;

  // input transaction: mode 1 loads the set fields, mode 0 advances one second
  typedef struct packed {
    logic               mode;
    logic [YEAR_W-1:0]  set_year;
    logic [MONTH_W-1:0] set_month;
    logic [DAY_W-1:0]   set_day;
    logic [HOUR_W-1:0]  set_hour;
    logic [MIN_W-1:0]   set_minute;
    logic [SEC_W-1:0]   set_second;
  } ccc_in_t;

  // result transaction: full time after the item plus status flags
  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WDAY_W-1:0]  weekday;
    logic [YDAY_W-1:0]  ordinal_day;
    logic               day_changed;
    logic               load_error;
  } ccc_out_t;

endpackage

[rtl/calendar_clock_counter.sv]
// calendar_clock_counter: real-time calendar counter with weekday and day of year
// depends on ccc_pkg for field widths, limits and the transaction types
//
// usage
//   in_valid/in_ready/in_data carry one transaction per item: mode 0 is a one
//   second tick, mode 1 loads set_year..set_second. a load with a field out of
//   range leaves the time as it was and returns load_error = 1.
//   out_valid/out_ready/out_data return one transaction per item with the full
//   time after it, the weekday (0 Sunday), the day of the year and the flags.
// timing
//   four register stages: input capture, divide by 100, load checks and weekday
//   sum, then mod 7 and the counter update into the result register. each item
//   passes through the four registers in that order.
//   one item per cycle while out_ready is high; each stage holds its own valid
//   bit, so the block keeps taking items into empty stages while a result waits.
// reset
//   rst_n low for one clock empties the pipeline and sets the time to
//   Saturday 1 January 2000, 00:00:00 (day of year 1).
// stall
//   with out_ready low the result register holds; stages behind it fill up
//   and in_ready drops only once every stage is occupied.
module calendar_clock_counter
  import ccc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ccc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ccc_out_t out_data
);

  // y / 100 as (y * 5243) >> 19, exact for every 14-bit year
  localparam int                     DIV_MUL_W = 13;
  localparam logic [DIV_MUL_W-1:0]   DIV_MUL   = 13'd5243;
  localparam int                     DIV_SHIFT = 19;
  localparam int                     CENT_W    = 8;
  localparam int                     PROD_W    = YEAR_W + DIV_MUL_W;
  localparam logic [YEAR_W-1:0]      CENT_LEN  = 14'd100;
  localparam int                     YY_W      = 7;
  localparam logic [YY_W-1:0]        YY_MAX    = 7'd99;
  localparam int                     WSUM_W    = 11;
  localparam logic [3:0]             MOD7      = 4'd7;
  localparam logic [MONTH_W-1:0]     FEB       = 4'd2;
  localparam logic [MONTH_W-1:0]     MONTH_SHIFT = 4'd12;

  // stage 1 payload: input, shifted zeller year and month, and century quotients
  typedef struct packed {
    ccc_in_t            din;
    logic [YEAR_W-1:0]  zyear;
    logic [MONTH_W-1:0] zmonth;
    logic [CENT_W-1:0]  cent_y;
    logic [CENT_W-1:0]  cent_z;
  } ccc_div_t;

  // stage 2 payload: checked load with weekday sum and year day
  typedef struct packed {
    ccc_in_t            din;
    logic               err;
    logic [WSUM_W-1:0]  wsum;
    logic [YDAY_W-1:0]  yday;
    logic [1:0]         ymod4;
    logic [YY_W-1:0]    ymod100;
    logic [1:0]         cmod4;
  } ccc_chk_t;

  // days in month m of a year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // days in a common year before the first of month m
  function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // zeller month term (13 * (m + 1)) / 5 less one, months 3..14
  function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      4'd13:   t = 6'd35;
      4'd14:   t = 6'd38;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // pipeline registers
  logic     va_r, vb_r, vc_r, out_valid_r;
  ccc_in_t  in_r;
  ccc_div_t p1_r, p1_nxt;
  ccc_chk_t p2_r, p2_nxt;
  ccc_out_t out_r, out_nxt;

  // calendar state
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [WDAY_W-1:0]  wday_r, wday_nxt;
  logic [YDAY_W-1:0]  yday_r, yday_nxt;
  // year mod 4, year mod 100 and century mod 4 drive the leap rule
  logic [1:0]         ymod4_r, ymod4_nxt;
  logic [YY_W-1:0]    ymod100_r, ymod100_nxt;
  logic [1:0]         cmod4_r, cmod4_nxt;

  // stage handshake
  logic out_free, c_free, b_free, a_free;
  logic c_go, b_go, a_go;

  assign out_free = !out_valid_r || out_ready;
  assign c_free   = !vc_r || out_free;
  assign b_free   = !vb_r || c_free;
  assign a_free   = !va_r || b_free;
  assign c_go     = vc_r && out_free;
  assign b_go     = vb_r && c_free;
  assign a_go     = va_r && b_free;
  assign in_ready = a_free;

  // stage 1: shifted year for zeller, divide both years by 100
  logic [PROD_W-1:0] prod_y, prod_z;
  always_comb begin
    p1_nxt.din = in_r;
    if (in_r.set_month <= FEB) begin
      p1_nxt.zyear  = in_r.set_year - YEAR_MIN;
      p1_nxt.zmonth = in_r.set_month + MONTH_SHIFT;
    end else begin
      p1_nxt.zyear  = in_r.set_year;
      p1_nxt.zmonth = in_r.set_month;
    end
    prod_y = {{DIV_MUL_W{1'b0}}, in_r.set_year} * {{YEAR_W{1'b0}}, DIV_MUL};
    prod_z = {{DIV_MUL_W{1'b0}}, p1_nxt.zyear} * {{YEAR_W{1'b0}}, DIV_MUL};
    p1_nxt.cent_y = prod_y[DIV_SHIFT +: CENT_W];
    p1_nxt.cent_z = prod_z[DIV_SHIFT +: CENT_W];
  end

  // stage 2: leap test, range checks, weekday sum and year day of the load
  logic [YEAR_W-1:0] rem_y, rem_z;
  logic [YY_W-1:0]   yy;
  logic              leap_set;
  always_comb begin
    rem_y = p1_r.din.set_year - ({{(YEAR_W-CENT_W){1'b0}}, p1_r.cent_y} * CENT_LEN);
    rem_z = p1_r.zyear - ({{(YEAR_W-CENT_W){1'b0}}, p1_r.cent_z} * CENT_LEN);
    yy    = rem_z[YY_W-1:0];
    leap_set = (p1_r.din.set_year[1:0] == 2'd0) &&
               ((rem_y != '0) || (p1_r.cent_y[1:0] == 2'd0));

    p2_nxt.din = p1_r.din;
    p2_nxt.err = (p1_r.din.set_year < YEAR_MIN) || (p1_r.din.set_year > YEAR_MAX) ||
                 (p1_r.din.set_month < MONTH_MIN) || (p1_r.din.set_month > MONTH_MAX) ||
                 (p1_r.din.set_day < DAY_MIN) ||
                 (p1_r.din.set_day > month_days(p1_r.din.set_month, leap_set)) ||
                 (p1_r.din.set_hour > HOUR_MAX) || (p1_r.din.set_minute > MIN_MAX) ||
                 (p1_r.din.set_second > SEC_MAX);

    // c/4 + 5c + yy + yy/4 + month term + d - 1, reduced mod 7 in stage 3
    p2_nxt.wsum = {{(WSUM_W-CENT_W+2){1'b0}}, p1_r.cent_z[CENT_W-1:2]} +
                  {1'b0, p1_r.cent_z, 2'b00} +
                  {{(WSUM_W-CENT_W){1'b0}}, p1_r.cent_z} +
                  {{(WSUM_W-YY_W){1'b0}}, yy} +
                  {{(WSUM_W-YY_W+2){1'b0}}, yy[YY_W-1:2]} +
                  {{(WSUM_W-6){1'b0}}, zeller_term(p1_r.zmonth)} +
                  {{(WSUM_W-DAY_W){1'b0}}, p1_r.din.set_day};

    p2_nxt.yday = days_before(p1_r.din.set_month) +
                  {{(YDAY_W-DAY_W){1'b0}}, p1_r.din.set_day} +
                  {{(YDAY_W-1){1'b0}}, (leap_set && (p1_r.din.set_month > FEB))};
    p2_nxt.ymod4   = p1_r.din.set_year[1:0];
    p2_nxt.ymod100 = rem_y[YY_W-1:0];
    p2_nxt.cmod4   = p1_r.cent_y[1:0];
  end

  // stage 3: weekday mod 7 by octal digit folding (8 is 1 mod 7)
  logic [4:0]        fold1;
  logic [3:0]        fold2;
  logic [WDAY_W-1:0] wday_load;
  always_comb begin
    fold1 = {3'b000, p2_r.wsum[10:9]} + {2'b00, p2_r.wsum[8:6]} +
            {2'b00, p2_r.wsum[5:3]} + {2'b00, p2_r.wsum[2:0]};
    fold2 = {2'b00, fold1[4:3]} + {1'b0, fold1[2:0]};
    if (fold2 >= MOD7) begin
      wday_load = WDAY_W'(fold2 - MOD7);
    end else begin
      wday_load = fold2[WDAY_W-1:0];
    end
  end

  // stage 3: load or one second tick with the carry chain
  logic cur_leap, changed;
  always_comb begin
    cur_leap    = (ymod4_r == 2'd0) && ((ymod100_r != '0) || (cmod4_r == 2'd0));
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    wday_nxt    = wday_r;
    yday_nxt    = yday_r;
    ymod4_nxt   = ymod4_r;
    ymod100_nxt = ymod100_r;
    cmod4_nxt   = cmod4_r;
    changed     = 1'b0;
    if (p2_r.din.mode) begin
      if (!p2_r.err) begin
        sec_nxt     = p2_r.din.set_second;
        min_nxt     = p2_r.din.set_minute;
        hour_nxt    = p2_r.din.set_hour;
        day_nxt     = p2_r.din.set_day;
        month_nxt   = p2_r.din.set_month;
        year_nxt    = p2_r.din.set_year;
        wday_nxt    = wday_load;
        yday_nxt    = p2_r.yday;
        ymod4_nxt   = p2_r.ymod4;
        ymod100_nxt = p2_r.ymod100;
        cmod4_nxt   = p2_r.cmod4;
      end
    end else if (sec_r != SEC_MAX) begin
      sec_nxt = sec_r + 1'b1;
    end else begin
      sec_nxt = '0;
      if (min_r != MIN_MAX) begin
        min_nxt = min_r + 1'b1;
      end else begin
        min_nxt = '0;
        if (hour_r != HOUR_MAX) begin
          hour_nxt = hour_r + 1'b1;
        end else begin
          // midnight
          hour_nxt = '0;
          changed  = 1'b1;
          wday_nxt = (wday_r == WDAY_MAX) ? '0 : wday_r + 1'b1;
          yday_nxt = yday_r + 1'b1;
          if (day_r != month_days(month_r, cur_leap)) begin
            day_nxt = day_r + 1'b1;
          end else begin
            day_nxt = DAY_MIN;
            if (month_r != MONTH_MAX) begin
              month_nxt = month_r + 1'b1;
            end else begin
              // new year
              month_nxt = MONTH_MIN;
              yday_nxt  = YDAY_RST;
              if (year_r == YEAR_MAX) begin
                year_nxt    = YEAR_MIN;
                ymod4_nxt   = 2'd1;
                ymod100_nxt = 7'd1;
                cmod4_nxt   = 2'd0;
              end else begin
                year_nxt  = year_r + 1'b1;
                ymod4_nxt = ymod4_r + 1'b1;
                if (ymod100_r == YY_MAX) begin
                  ymod100_nxt = '0;
                  cmod4_nxt   = cmod4_r + 1'b1;
                end else begin
                  ymod100_nxt = ymod100_r + 1'b1;
                end
              end
            end
          end
        end
      end
    end

    out_nxt.second      = sec_nxt;
    out_nxt.minute      = min_nxt;
    out_nxt.hour        = hour_nxt;
    out_nxt.day         = day_nxt;
    out_nxt.month       = month_nxt;
    out_nxt.year        = year_nxt;
    out_nxt.weekday     = wday_nxt;
    out_nxt.ordinal_day = yday_nxt;
    out_nxt.day_changed = changed;
    out_nxt.load_error  = p2_r.din.mode && p2_r.err;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        va_r <= in_valid;
      end
      if (b_free) begin
        vb_r <= va_r;
      end
      if (c_free) begin
        vc_r <= vb_r;
      end
      if (out_free) begin
        out_valid_r <= vc_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      in_r <= in_data;
    end
    if (a_go) begin
      p1_r <= p1_nxt;
    end
    if (b_go) begin
      p2_r <= p2_nxt;
    end
    if (c_go) begin
      out_r <= out_nxt;
    end
  end

  // calendar state, updated as each transaction enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= '0;
      min_r     <= '0;
      hour_r    <= '0;
      day_r     <= DAY_MIN;
      month_r   <= MONTH_MIN;
      year_r    <= YEAR_RST;
      wday_r    <= WDAY_RST;
      yday_r    <= YDAY_RST;
      ymod4_r   <= 2'd0;
      ymod100_r <= '0;
      cmod4_r   <= 2'd0;
    end else if (c_go) begin
      sec_r     <= sec_nxt;
      min_r     <= min_nxt;
      hour_r    <= hour_nxt;
      day_r     <= day_nxt;
      month_r   <= month_nxt;
      year_r    <= year_nxt;
      wday_r    <= wday_nxt;
      yday_r    <= yday_nxt;
      ymod4_r   <= ymod4_nxt;
      ymod100_r <= ymod100_nxt;
      cmod4_r   <= cmod4_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/ccc_checker.sv]
// ccc_checker: port-level assertions for calendar_clock_counter, bound to the top level
// depends on ccc_pkg for the result transaction type and field limits
module ccc_checker
  import ccc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ccc_out_t out_data
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // reported fields are in range; day and day of year have only a lower bound
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.second <= SEC_MAX) && (out_data.minute <= MIN_MAX) &&
                  (out_data.hour <= HOUR_MAX) && (out_data.weekday <= WDAY_MAX) &&
                  (out_data.month >= MONTH_MIN) && (out_data.month <= MONTH_MAX) &&
                  (out_data.day >= DAY_MIN) && (out_data.year >= YEAR_MIN) &&
                  (out_data.year <= YEAR_MAX) && (out_data.ordinal_day != '0))
    else $error("result time out of range");

  // a midnight carry shows 00:00:00 and never comes with a refused load
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.day_changed |->
      (out_data.second == '0) && (out_data.minute == '0) && (out_data.hour == '0) &&
      !out_data.load_error)
    else $error("day change without midnight");

  // reset empties the pipeline
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
